>>> hdl/slcd_pkg.sv
// shared types, constants and the crc-8 step for the sync/length/crc8 deframer
// no dependencies; used by slcd_parser and sync_length_crc8_deframer
package slcd_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_INIT    = 8'h00;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd251;

   // result kinds, carried on tuser
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_END     = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      PH_HUNT1   = 6'b000001,
      PH_HUNT2   = 6'b000010,
      PH_TYPE    = 6'b000100,
      PH_LEN     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_CHECK   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] frame_type;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic       last;
      logic [7:0] payload_length;
      logic       crc_ok;
   } result_type;

   // msb-first crc-8 over one byte, no reflection
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/slcd_parser.sv
// frame parser: phase machine, header capture, payload counter and running crc-8
// depends on slcd_pkg
module slcd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic [7:0]          max_payload,
   output slcd_pkg::result_type result
);

   slcd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] count_next;
   logic [7:0] crc_step;

   assign count_next = count_ff + 8'd1;
   // type byte restarts the crc from its initial value
   assign crc_step = slcd_pkg::crc8_update(
      (phase_ff == slcd_pkg::PH_TYPE) ? slcd_pkg::CRC_INIT : crc_ff, data_byte);

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;

      result                = '0;
      result.kind           = slcd_pkg::KIND_PAYLOAD;
      result.frame_type     = type_ff;
      result.payload_length = length_ff;

      unique case (phase_ff)
         slcd_pkg::PH_HUNT2: begin
            if (data_byte == slcd_pkg::SYNC_SECOND) begin
               phase_in = slcd_pkg::PH_TYPE;
            end else if (data_byte != slcd_pkg::SYNC_FIRST) begin
               phase_in = slcd_pkg::PH_HUNT1;
            end
         end
         slcd_pkg::PH_TYPE: begin
            type_in  = data_byte;
            crc_in   = crc_step;
            phase_in = slcd_pkg::PH_LEN;
         end
         slcd_pkg::PH_LEN: begin
            length_in = data_byte;
            crc_in    = crc_step;
            count_in  = 8'd0;
            if (data_byte > max_payload) begin
               phase_in              = slcd_pkg::PH_HUNT1;
               result.valid          = 1'b1;
               result.kind           = slcd_pkg::KIND_DROP;
               result.payload_length = data_byte;
            end else if (data_byte == 8'd0) begin
               phase_in = slcd_pkg::PH_CHECK;
            end else begin
               phase_in = slcd_pkg::PH_PAYLOAD;
            end
         end
         slcd_pkg::PH_PAYLOAD: begin
            crc_in              = crc_step;
            count_in            = count_next;
            result.valid        = 1'b1;
            result.kind         = slcd_pkg::KIND_PAYLOAD;
            result.payload_byte = data_byte;
            result.byte_index   = count_ff;
            result.last         = (count_next == length_ff);
            if (count_next == length_ff) begin
               phase_in = slcd_pkg::PH_CHECK;
            end
         end
         slcd_pkg::PH_CHECK: begin
            phase_in      = slcd_pkg::PH_HUNT1;
            result.valid  = 1'b1;
            result.kind   = slcd_pkg::KIND_END;
            result.crc_ok = (data_byte == crc_ff);
         end
         default: begin
            // first sync byte hunt, also covers unused codes
            phase_in = (data_byte == slcd_pkg::SYNC_FIRST) ? slcd_pkg::PH_HUNT2
                                                           : slcd_pkg::PH_HUNT1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= slcd_pkg::PH_HUNT1;
         type_ff   <= 8'd0;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         crc_ff    <= slcd_pkg::CRC_INIT;
      end else if (step) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

>>> hdl/sync_length_crc8_deframer.sv
// sync_length_crc8_deframer: input word register, parser and result register
// a word waits in the input register until the result register is free; then its result
// is captured there and held for the sink, which can stall both registers
// throughput: one word per cycle unless the sink stalls, set by the single-pass parser
// between the registers; a word with no result also waits for a free result register
// reset: synchronous, active high; clears the hunt state, both valids, max_payload to 251
// depends on slcd_pkg and slcd_parser
module sync_length_crc8_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                    // [23:16] byte_index, [31:24] payload_length,
                                    // [32] crc_ok, [39:33] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // max_payload
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] max_payload_ff;
   logic       out_valid_ff;
   slcd_pkg::result_type out_ff;
   slcd_pkg::result_type result;
   logic       out_free;
   logic       advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   slcd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .max_payload (max_payload_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         max_payload_ff <= slcd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= result.valid;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            max_payload_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.crc_ok, out_ff.payload_length, out_ff.byte_index,
                        out_ff.payload_byte, out_ff.frame_type};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

endmodule
